@@ design/cts_pkg.sv @@
// ---------------------------------------------------------------------------
// cts_pkg: shared types and constants for the token scanner
// Token kinds, scanner states, error codes, beat structs and char classes.
// ---------------------------------------------------------------------------
`default_nettype none
package cts_pkg;

    localparam int OFFSET_BITS_DEF = 24;
    localparam int FIELD_W = 24;
    localparam int KIND_W = 6;
    localparam int ERR_W = 3;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [KIND_W-1:0] K_DOT    = 6'd7;
    localparam logic [KIND_W-1:0] K_STRING = 6'd43;
    localparam logic [KIND_W-1:0] K_CHAR   = 6'd44;
    localparam logic [KIND_W-1:0] K_NUMBER = 6'd45;
    localparam logic [KIND_W-1:0] K_WORD   = 6'd46;
    localparam logic [KIND_W-1:0] K_END    = 6'd47;
    localparam logic [KIND_W-1:0] K_NONE   = 6'd63;

    localparam logic [ERR_W-1:0] E_NONE      = 3'd0;
    localparam logic [ERR_W-1:0] E_COMMENT   = 3'd1;
    localparam logic [ERR_W-1:0] E_STRING    = 3'd2;
    localparam logic [ERR_W-1:0] E_EMPTY_CH  = 3'd3;
    localparam logic [ERR_W-1:0] E_BAD_CH    = 3'd4;
    localparam logic [ERR_W-1:0] E_UNEXPECT  = 3'd5;

    typedef enum logic [4:0] {
        S_IDLE, S_OP, S_LINE, S_BLOCK, S_STAR, S_STRING, S_CH_OPEN, S_CH_ESC,
        S_CH_CLOSE, S_NUM_INT, S_NUM_DOT, S_NUM_FRAC, S_WORD
    } t_scan_state;

    typedef struct packed {
        logic       mode;
        logic [7:0] byte_value;
    } t_in_beat;

    typedef struct packed {
        logic [KIND_W-1:0]  token_kind;
        logic [FIELD_W-1:0] start_offset;
        logic [FIELD_W-1:0] text_length;
        logic [FIELD_W-1:0] line_number;
        logic [ERR_W-1:0]   error_code;
        logic               last_of_run;
    } t_out_beat;

    // One classified item: up to three results, count in n.
    typedef struct packed {
        logic [1:0] n;
        t_out_beat  r0;
        t_out_beat  r1;
        t_out_beat  r2;
    } t_run;

    function automatic logic [KIND_W-1:0] single_kind(input logic [7:0] c);
        case (c)
            8'h28: single_kind = 6'd0;  8'h29: single_kind = 6'd1;
            8'h7b: single_kind = 6'd2;  8'h7d: single_kind = 6'd3;
            8'h5b: single_kind = 6'd4;  8'h5d: single_kind = 6'd5;
            8'h2c: single_kind = 6'd6;  8'h2e: single_kind = 6'd7;
            8'h3b: single_kind = 6'd8;  8'h7e: single_kind = 6'd9;
            8'h3f: single_kind = 6'd10; 8'h3a: single_kind = 6'd11;
            default: single_kind = K_NONE;
        endcase
    endfunction

    function automatic logic [KIND_W-1:0] op_first(input logic [7:0] c);
        case (c)
            8'h21: op_first = 6'd12; 8'h3d: op_first = 6'd14;
            8'h2b: op_first = 6'd16; 8'h2d: op_first = 6'd19;
            8'h2a: op_first = 6'd23; 8'h25: op_first = 6'd25;
            8'h5e: op_first = 6'd27; 8'h26: op_first = 6'd29;
            8'h7c: op_first = 6'd32; 8'h3c: op_first = 6'd35;
            8'h3e: op_first = 6'd38; 8'h2f: op_first = 6'd41;
            default: op_first = K_NONE;
        endcase
    endfunction

    function automatic logic [KIND_W-1:0] op_pair(input logic [7:0] a,
                                                  input logic [7:0] b);
        logic eq;
        eq = (b == 8'h3d);
        op_pair = K_NONE;
        case (a)
            8'h21: if (eq) op_pair = 6'd13;
            8'h3d: if (eq) op_pair = 6'd15;
            8'h2b: if (b == 8'h2b) op_pair = 6'd17; else if (eq) op_pair = 6'd18;
            8'h2d: if (b == 8'h2d) op_pair = 6'd20; else if (eq) op_pair = 6'd21;
                   else if (b == 8'h3e) op_pair = 6'd22;
            8'h2a: if (eq) op_pair = 6'd24;
            8'h25: if (eq) op_pair = 6'd26;
            8'h5e: if (eq) op_pair = 6'd28;
            8'h26: if (b == 8'h26) op_pair = 6'd30; else if (eq) op_pair = 6'd31;
            8'h7c: if (b == 8'h7c) op_pair = 6'd33; else if (eq) op_pair = 6'd34;
            8'h3c: if (b == 8'h3c) op_pair = 6'd36; else if (eq) op_pair = 6'd37;
            8'h3e: if (b == 8'h3e) op_pair = 6'd39; else if (eq) op_pair = 6'd40;
            8'h2f: if (eq) op_pair = 6'd42;
            default: op_pair = K_NONE;
        endcase
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        is_digit = (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        is_alpha = ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a))
                   || (c == 8'h5f);
    endfunction

endpackage
`default_nettype wire

@@ design/cts_front.sv @@
// ---------------------------------------------------------------------------
// cts_front: scanner state machine
// Takes one beat per cycle when fired; produces the whole run of results.
// ---------------------------------------------------------------------------
`default_nettype none
module cts_front #(
    parameter int OFFSET_BITS = cts_pkg::OFFSET_BITS_DEF
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_fire,
    input  cts_pkg::t_in_beat  i_beat,
    output cts_pkg::t_run      o_run
);
    localparam int OB = OFFSET_BITS;
    localparam logic [OB-1:0] SAT = {OB{1'b1}};

    cts_pkg::t_scan_state r_state, n_state;
    logic [7:0]    r_pend, n_pend;
    logic [OB-1:0] r_start, n_start, r_off, n_off, r_line, n_line, r_cline, n_cline;
    logic          r_halt, n_halt;

    function automatic logic [OB-1:0] sinc(input logic [OB-1:0] v);
        sinc = (v == SAT) ? v : v + 1'b1;
    endfunction

    function automatic logic [cts_pkg::FIELD_W-1:0] wide(input logic [OB-1:0] v);
        wide = cts_pkg::FIELD_W'({{(64 - OB){1'b0}}, v});
    endfunction

    cts_pkg::t_out_beat res [3];
    logic [1:0] cnt;
    logic [7:0] c;
    logic [OB-1:0] len, dot;

    always_comb begin
        logic go_idle;
        logic [cts_pkg::KIND_W-1:0] k;
        n_state = r_state; n_pend = r_pend; n_start = r_start; n_off = r_off;
        n_line = r_line; n_cline = r_cline; n_halt = r_halt;
        cnt = 2'd0;
        for (int i = 0; i < 3; i++) res[i] = '0;
        c = i_beat.byte_value;
        len = (r_off >= r_start) ? r_off - r_start : '0;
        dot = (r_off != '0) ? r_off - 1'b1 : '0;
        go_idle = 1'b0;
        k = '0;

        if (i_beat.mode) begin
            if (!r_halt) begin
                case (r_state)
                    cts_pkg::S_OP: begin
                        res[0] = '{cts_pkg::op_first(r_pend), wide(r_start), 24'd1,
                                   wide(r_line), cts_pkg::E_NONE, 1'b0};
                        cnt = 2'd1;
                    end
                    cts_pkg::S_NUM_INT, cts_pkg::S_NUM_FRAC: begin
                        res[0] = '{cts_pkg::K_NUMBER, wide(r_start), wide(len),
                                   wide(r_line), cts_pkg::E_NONE, 1'b0};
                        cnt = 2'd1;
                    end
                    cts_pkg::S_WORD: begin
                        res[0] = '{cts_pkg::K_WORD, wide(r_start), wide(len),
                                   wide(r_line), cts_pkg::E_NONE, 1'b0};
                        cnt = 2'd1;
                    end
                    cts_pkg::S_NUM_DOT: begin
                        res[0] = '{cts_pkg::K_NUMBER, wide(r_start),
                                   wide((dot >= r_start) ? dot - r_start : '0),
                                   wide(r_line), cts_pkg::E_NONE, 1'b0};
                        res[1] = '{cts_pkg::K_DOT, wide(dot), 24'd1,
                                   wide(r_line), cts_pkg::E_NONE, 1'b0};
                        cnt = 2'd2;
                    end
                    default: ;
                endcase
                case (r_state)
                    cts_pkg::S_BLOCK, cts_pkg::S_STAR: begin
                        res[0] = '{6'd0, wide(r_off), 24'd0, wide(r_cline),
                                   cts_pkg::E_COMMENT, 1'b0};
                        cnt = 2'd1;
                    end
                    cts_pkg::S_STRING: begin
                        res[0] = '{6'd0, wide(r_off), 24'd0, wide(r_line),
                                   cts_pkg::E_STRING, 1'b0};
                        cnt = 2'd1;
                    end
                    cts_pkg::S_CH_OPEN, cts_pkg::S_CH_ESC, cts_pkg::S_CH_CLOSE: begin
                        res[0] = '{6'd0, wide(r_off), 24'd0, wide(r_line),
                                   cts_pkg::E_BAD_CH, 1'b0};
                        cnt = 2'd1;
                    end
                    default: begin
                        res[cnt] = '{cts_pkg::K_END, wide(r_off), 24'd0, wide(r_line),
                                     cts_pkg::E_NONE, 1'b0};
                        cnt = cnt + 2'd1;
                    end
                endcase
            end
            n_state = cts_pkg::S_IDLE; n_pend = '0; n_start = '0; n_off = '0;
            n_line = OB'(1); n_cline = OB'(1); n_halt = 1'b0;
        end else if (!r_halt) begin
            // first pass: token flushed by this byte, then decide from idle
            case (r_state)
                cts_pkg::S_IDLE: go_idle = 1'b1;
                cts_pkg::S_OP: begin
                    if (r_pend == 8'h2f && c == 8'h2f) n_state = cts_pkg::S_LINE;
                    else if (r_pend == 8'h2f && c == 8'h2a) begin
                        n_cline = r_line; n_state = cts_pkg::S_BLOCK;
                    end else begin
                        k = cts_pkg::op_pair(r_pend, c);
                        if (k != cts_pkg::K_NONE) begin
                            res[0] = '{k, wide(r_start), 24'd2, wide(r_line),
                                       cts_pkg::E_NONE, 1'b0};
                            cnt = 2'd1; n_state = cts_pkg::S_IDLE;
                        end else begin
                            res[0] = '{cts_pkg::op_first(r_pend), wide(r_start), 24'd1,
                                       wide(r_line), cts_pkg::E_NONE, 1'b0};
                            cnt = 2'd1; go_idle = 1'b1;
                        end
                    end
                end
                cts_pkg::S_LINE:
                    if (c == 8'h0a) begin
                        n_line = sinc(r_line); n_state = cts_pkg::S_IDLE;
                    end
                cts_pkg::S_BLOCK:
                    if (c == 8'h2a) n_state = cts_pkg::S_STAR;
                    else if (c == 8'h0a) n_line = sinc(r_line);
                cts_pkg::S_STAR:
                    if (c == 8'h2f) n_state = cts_pkg::S_IDLE;
                    else if (c != 8'h2a) begin
                        if (c == 8'h0a) n_line = sinc(r_line);
                        n_state = cts_pkg::S_BLOCK;
                    end
                cts_pkg::S_STRING:
                    if (c == 8'h22) begin
                        res[0] = '{cts_pkg::K_STRING, wide(r_start), wide(len),
                                   wide(r_line), cts_pkg::E_NONE, 1'b0};
                        cnt = 2'd1; n_state = cts_pkg::S_IDLE;
                    end else if (c == 8'h0a) n_line = sinc(r_line);
                cts_pkg::S_CH_OPEN:
                    if (c == 8'h27) begin
                        res[0] = '{6'd0, wide(r_off), 24'd0, wide(r_line),
                                   cts_pkg::E_EMPTY_CH, 1'b0};
                        cnt = 2'd1; n_halt = 1'b1; n_state = cts_pkg::S_IDLE;
                    end else n_state = (c == 8'h5c) ? cts_pkg::S_CH_ESC
                                                    : cts_pkg::S_CH_CLOSE;
                cts_pkg::S_CH_ESC: n_state = cts_pkg::S_CH_CLOSE;
                cts_pkg::S_CH_CLOSE: begin
                    if (c == 8'h27) begin
                        res[0] = '{cts_pkg::K_CHAR, wide(r_start), wide(len),
                                   wide(r_line), cts_pkg::E_NONE, 1'b0};
                        cnt = 2'd1;
                    end else begin
                        res[0] = '{6'd0, wide(r_off), 24'd0, wide(r_line),
                                   cts_pkg::E_BAD_CH, 1'b0};
                        cnt = 2'd1; n_halt = 1'b1;
                    end
                    n_state = cts_pkg::S_IDLE;
                end
                cts_pkg::S_NUM_INT:
                    if (c == 8'h2e) n_state = cts_pkg::S_NUM_DOT;
                    else if (!cts_pkg::is_digit(c)) begin
                        res[0] = '{cts_pkg::K_NUMBER, wide(r_start), wide(len),
                                   wide(r_line), cts_pkg::E_NONE, 1'b0};
                        cnt = 2'd1; go_idle = 1'b1;
                    end
                cts_pkg::S_NUM_DOT:
                    if (cts_pkg::is_digit(c)) n_state = cts_pkg::S_NUM_FRAC;
                    else begin
                        res[0] = '{cts_pkg::K_NUMBER, wide(r_start),
                                   wide((dot >= r_start) ? dot - r_start : '0),
                                   wide(r_line), cts_pkg::E_NONE, 1'b0};
                        res[1] = '{cts_pkg::K_DOT, wide(dot), 24'd1,
                                   wide(r_line), cts_pkg::E_NONE, 1'b0};
                        cnt = 2'd2; go_idle = 1'b1;
                    end
                cts_pkg::S_NUM_FRAC:
                    if (!cts_pkg::is_digit(c)) begin
                        res[0] = '{cts_pkg::K_NUMBER, wide(r_start), wide(len),
                                   wide(r_line), cts_pkg::E_NONE, 1'b0};
                        cnt = 2'd1; go_idle = 1'b1;
                    end
                cts_pkg::S_WORD:
                    if (!(cts_pkg::is_alpha(c) || cts_pkg::is_digit(c))) begin
                        res[0] = '{cts_pkg::K_WORD, wide(r_start), wide(len),
                                   wide(r_line), cts_pkg::E_NONE, 1'b0};
                        cnt = 2'd1; go_idle = 1'b1;
                    end
                default: go_idle = 1'b1;
            endcase
            // second pass: start a new token from this byte
            if (go_idle) begin
                n_state = cts_pkg::S_IDLE;
                k = cts_pkg::single_kind(c);
                if (k != cts_pkg::K_NONE) begin
                    res[cnt] = '{k, wide(r_off), 24'd1, wide(r_line),
                                 cts_pkg::E_NONE, 1'b0};
                    cnt = cnt + 2'd1;
                end else if (cts_pkg::op_first(c) != cts_pkg::K_NONE) begin
                    n_pend = c; n_start = r_off; n_state = cts_pkg::S_OP;
                end else if (c == 8'h22) begin
                    n_start = sinc(r_off); n_state = cts_pkg::S_STRING;
                end else if (c == 8'h27) begin
                    n_start = sinc(r_off); n_state = cts_pkg::S_CH_OPEN;
                end else if (c == 8'h20 || c == 8'h0d || c == 8'h09) begin
                end else if (c == 8'h0a) begin
                    n_line = sinc(r_line);
                end else if (cts_pkg::is_digit(c)) begin
                    n_start = r_off; n_state = cts_pkg::S_NUM_INT;
                end else if (cts_pkg::is_alpha(c)) begin
                    n_start = r_off; n_state = cts_pkg::S_WORD;
                end else begin
                    res[cnt] = '{6'd0, wide(r_off), 24'd0, wide(r_line),
                                 cts_pkg::E_UNEXPECT, 1'b0};
                    cnt = cnt + 2'd1; n_halt = 1'b1;
                end
            end
            if (!n_halt) n_off = sinc(r_off);
        end
        if (cnt != 2'd0) res[cnt - 2'd1].last_of_run = 1'b1;
        o_run = '{cnt, res[0], res[1], res[2]};
        if (!i_fire) o_run.n = 2'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cts_pkg::S_IDLE; r_pend <= '0; r_start <= '0; r_off <= '0;
            r_line <= OB'(1); r_cline <= OB'(1); r_halt <= 1'b0;
        end else if (i_fire) begin
            r_state <= n_state; r_pend <= n_pend; r_start <= n_start; r_off <= n_off;
            r_line <= n_line; r_cline <= n_cline; r_halt <= n_halt;
        end
    end
endmodule
`default_nettype wire

@@ design/cts_queue.sv @@
// ---------------------------------------------------------------------------
// cts_queue: result queue
// Takes 0..3 result beats per cycle, hands out one per cycle when popped.
// ---------------------------------------------------------------------------
`default_nettype none
module cts_queue (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  cts_pkg::t_run       i_run,
    output logic                o_room,
    output logic                o_valid,
    input  wire                 i_pop,
    output cts_pkg::t_out_beat  o_beat
);
    localparam int D = cts_pkg::QUEUE_DEPTH * 2;
    localparam int AW = $clog2(D);

    cts_pkg::t_out_beat r_mem [D];
    logic [AW-1:0] r_rd, r_wr;
    logic [AW:0]   r_cnt, n_cnt;
    logic [AW:0]   w_free;

    assign o_valid = (r_cnt != '0);
    assign o_beat  = r_mem[r_rd];
    // room for a full run even if nothing pops this cycle
    assign w_free = (AW + 1)'(D) - r_cnt;
    assign o_room = w_free >= (AW + 1)'(3);
    assign n_cnt = r_cnt + (AW + 1)'(i_run.n) - (AW + 1)'(o_valid && i_pop);

    always_ff @(posedge i_clk) begin
        if (i_run.n != 2'd0) r_mem[r_wr] <= i_run.r0;
        if (i_run.n >= 2'd2) r_mem[r_wr + AW'(1)] <= i_run.r1;
        if (i_run.n == 2'd3) r_mem[r_wr + AW'(2)] <= i_run.r2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd <= '0; r_wr <= '0; r_cnt <= '0;
        end else begin
            r_wr <= r_wr + AW'(i_run.n);
            if (o_valid && i_pop) r_rd <= r_rd + AW'(1);
            r_cnt <= n_cnt;
        end
    end
endmodule
`default_nettype wire

@@ design/c_like_token_scanner_unit.sv @@
// ---------------------------------------------------------------------------
// c_like_token_scanner_unit: C-style lexical scanner
// Source bytes in, token beats out, through a small result queue.
// ---------------------------------------------------------------------------
// Output: token beats are built combinationally, then queued in order.
// Throughput: one input beat per cycle; o_in_stall rises only while the
//   result queue lacks room for three beats, so a run of multi-token bytes
//   is paced by the single-beat output port.
// Reset: synchronous, active low; scanner state back to idle, line one,
//   queue emptied. No clearing pass.
`default_nettype none
module c_like_token_scanner_unit #(
    parameter int OFFSET_BITS = cts_pkg::OFFSET_BITS_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  cts_pkg::t_in_beat   i_in_data,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output cts_pkg::t_out_beat  o_out_data
);
    cts_pkg::t_run w_run;
    logic          w_room;
    logic          w_fire;

    // front accepts whenever the queue can absorb a worst-case run
    assign o_in_stall = !w_room;
    assign w_fire     = i_in_valid && w_room;

    cts_front #(.OFFSET_BITS(OFFSET_BITS)) u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_fire (w_fire),
        .i_beat (i_in_data),
        .o_run  (w_run)
    );

    // back side: queue drains one beat per cycle while i_out_stall is low
    cts_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_run  (w_run),
        .o_room (w_room),
        .o_valid(o_out_valid),
        .i_pop  (!i_out_stall),
        .o_beat (o_out_data)
    );
endmodule
`default_nettype wire
